// File: rtl/gapp_pkg.sv
// Pack planner package: field widths, register indexes, status codes
// and the word types that pass from front end to back end.
// No dependencies.
package gapp_pkg;

    localparam int MAX_TILES   = 1048576;
    localparam int QUEUE_DEPTH = 4;

    localparam int KEY_W     = 64;
    localparam int FACE_W    = 8;
    localparam int LEVEL_W   = 8;
    localparam int PAYLOAD_W = 33;
    localparam int START_W   = 20;
    localparam int COUNT_W   = 21;
    localparam int STATUS_W  = 2;
    localparam int TARGET_W  = 41;
    localparam int HEADER_W  = 13;
    localparam int BYTES_W   = 42;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_KEY_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAYLOAD   = 2'd2;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 41'd16777216;
    localparam logic [HEADER_W-1:0] HEADER_RESET = 13'd64;

    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

    // results caused by one tile: first always valid, second when two is set
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_plan;

endpackage

// File: rtl/gapp_front.sv
// Pack planner front end: config registers, tile checks, range state.
// Emits one plan word per tile that closes a range, ends the list or is refused with an error status.
// Depends on gapp_pkg.
module gapp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gapp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gapp_pkg::TARGET_W-1:0]    i_cfg_data,
    input  logic                             i_tile_valid,
    output logic                             o_tile_ready,
    input  logic [gapp_pkg::KEY_W-1:0]       i_tile_key,
    input  logic [gapp_pkg::FACE_W-1:0]      i_tile_face,
    input  logic [gapp_pkg::LEVEL_W-1:0]     i_tile_level,
    input  logic [gapp_pkg::PAYLOAD_W-1:0]   i_payload_size,
    input  logic                             i_final_tile,
    input  logic                             i_full,
    output logic                             o_push,
    output gapp_pkg::t_plan                  o_plan
);
    import gapp_pkg::*;

    localparam logic [COUNT_W-1:0] TILE_LIMIT = COUNT_W'(MAX_TILES);
    localparam int RND_W = BYTES_W + 1;

    logic [TARGET_W-1:0] r_target;
    logic [HEADER_W-1:0] r_header;
    logic [COUNT_W-1:0]  r_tile_counter, n_tile_counter;
    logic [START_W-1:0]  r_open_start, n_open_start;
    logic [BYTES_W-1:0]  r_open_bytes, n_open_bytes;
    logic [FACE_W-1:0]   r_open_face, n_open_face;
    logic [LEVEL_W-1:0]  r_open_level, n_open_level;
    logic [KEY_W-1:0]    r_prev_key, n_prev_key;
    logic                r_range_open, n_range_open;
    logic                r_error, n_error;

    logic                w_accept;
    logic [RND_W-1:0]    w_round;
    logic [RND_W-1:0]    w_cand;
    logic [HEADER_W:0]   w_hdr_round;
    logic [BYTES_W-1:0]  w_new_bytes;
    logic                w_join;
    logic                w_close;
    logic [COUNT_W-1:0]  w_idx_next;
    logic [START_W-1:0]  w_start_after;

    assign o_tile_ready = !i_full;
    assign w_accept     = i_tile_valid && o_tile_ready;

    assign w_round = {({1'b0, r_open_bytes[BYTES_W-1:3]}
                       + (BYTES_W-2)'(|r_open_bytes[2:0])), 3'b000};
    assign w_cand  = w_round + RND_W'(i_payload_size[PAYLOAD_W-2:0]);
    assign w_hdr_round = {({1'b0, r_header[HEADER_W-1:3]}
                           + (HEADER_W-2)'(|r_header[2:0])), 3'b000};
    assign w_new_bytes = BYTES_W'(w_hdr_round) + BYTES_W'(i_payload_size[PAYLOAD_W-2:0]);

    assign w_join = r_range_open && (i_tile_face == r_open_face)
                    && (i_tile_level == r_open_level)
                    && (w_cand <= RND_W'(r_target));
    assign w_close       = r_range_open && !w_join;
    assign w_idx_next    = r_tile_counter + COUNT_W'(1);
    assign w_start_after = w_join ? r_open_start : r_tile_counter[START_W-1:0];

    always_comb begin
        n_tile_counter = r_tile_counter;
        n_open_start   = r_open_start;
        n_open_bytes   = r_open_bytes;
        n_open_face    = r_open_face;
        n_open_level   = r_open_level;
        n_prev_key     = r_prev_key;
        n_range_open   = r_range_open;
        n_error        = r_error;
        o_push         = 1'b0;
        o_plan         = '0;
        if (w_accept && !r_error) begin
            if (r_tile_counter >= TILE_LIMIT) begin
                if (i_final_tile) begin
                    o_push            = 1'b1;
                    o_plan.first.last = 1'b1;
                    if (r_range_open) begin
                        o_plan.first.start = r_open_start;
                        o_plan.first.count = r_tile_counter - COUNT_W'(r_open_start);
                    end
                end
            end else if (i_payload_size[PAYLOAD_W-1]) begin
                n_error             = 1'b1;
                o_push              = 1'b1;
                o_plan.first.status = ST_PAYLOAD;
                o_plan.first.last   = 1'b1;
            end else if ((r_tile_counter != '0) && (i_tile_key <= r_prev_key)) begin
                n_error             = 1'b1;
                o_push              = 1'b1;
                o_plan.first.status = ST_KEY_ORDER;
                o_plan.first.last   = 1'b1;
            end else begin
                n_tile_counter = w_idx_next;
                n_prev_key     = i_tile_key;
                if (w_join) begin
                    n_open_bytes = w_cand[BYTES_W-1:0];
                end else begin
                    n_range_open = 1'b1;
                    n_open_start = r_tile_counter[START_W-1:0];
                    n_open_bytes = w_new_bytes;
                    n_open_face  = i_tile_face;
                    n_open_level = i_tile_level;
                end
                if (w_close) begin
                    o_push             = 1'b1;
                    o_plan.first.start = r_open_start;
                    o_plan.first.count = r_tile_counter - COUNT_W'(r_open_start);
                end
                if (i_final_tile) begin
                    o_push = 1'b1;
                    if (w_close) begin
                        o_plan.two          = 1'b1;
                        o_plan.second.start = w_start_after;
                        o_plan.second.count = w_idx_next - COUNT_W'(w_start_after);
                        o_plan.second.last  = 1'b1;
                    end else begin
                        o_plan.first.start = w_start_after;
                        o_plan.first.count = w_idx_next - COUNT_W'(w_start_after);
                        o_plan.first.last  = 1'b1;
                    end
                end
            end
            if (i_final_tile && !(r_tile_counter < TILE_LIMIT && n_error)) begin
                if (r_tile_counter < TILE_LIMIT || i_final_tile) begin
                    n_tile_counter = '0;
                    n_prev_key     = '0;
                    n_range_open   = 1'b0;
                    n_open_start   = '0;
                    n_open_bytes   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target       <= TARGET_RESET;
            r_header       <= HEADER_RESET;
            r_tile_counter <= '0;
            r_open_start   <= '0;
            r_open_bytes   <= '0;
            r_open_face    <= '0;
            r_open_level   <= '0;
            r_prev_key     <= '0;
            r_range_open   <= 1'b0;
            r_error        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET: r_target <= i_cfg_data;
                    CFG_HEADER: r_header <= i_cfg_data[HEADER_W-1:0];
                    default: ;
                endcase
            end
            r_tile_counter <= n_tile_counter;
            r_open_start   <= n_open_start;
            r_open_bytes   <= n_open_bytes;
            r_open_face    <= n_open_face;
            r_open_level   <= n_open_level;
            r_prev_key     <= n_prev_key;
            r_range_open   <= n_range_open;
            r_error        <= n_error;
        end
    end

endmodule

// File: rtl/gapp_queue.sv
// Pack planner plan queue between front end and back end.
// Small register FIFO of plan words. Depends on gapp_pkg.
module gapp_queue #(
    parameter int DEPTH = gapp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gapp_pkg::t_plan i_plan,
    input  logic            i_pop,
    output gapp_pkg::t_plan o_head,
    output logic            o_empty,
    output logic            o_full
);
    import gapp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_plan            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: rtl/gapp_back.sv
// Pack planner back end: unpacks plan words into range words and holds
// the output register. Depends on gapp_pkg.
module gapp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gapp_pkg::t_plan                 i_head,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_range_valid,
    input  logic                            i_range_ready,
    output logic [gapp_pkg::START_W-1:0]    o_range_start,
    output logic [gapp_pkg::COUNT_W-1:0]    o_range_count,
    output logic [gapp_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_last_result
);
    import gapp_pkg::*;

    t_plan   r_plan;
    logic    r_busy;
    logic    r_sel;
    t_result w_cur;
    logic    w_done;

    assign w_cur  = r_sel ? r_plan.second : r_plan.first;
    assign w_done = !r_busy || (i_range_ready && (r_sel || !r_plan.two));
    assign o_pop  = w_done && !i_empty;

    assign o_range_valid = r_busy;
    assign o_range_start = w_cur.start;
    assign o_range_count = w_cur.count;
    assign o_status      = w_cur.status;
    assign o_last_result = w_cur.last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_plan <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_sel  <= 1'b0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
        end else if (i_range_ready) begin
            r_sel  <= 1'b1;
        end
    end

endmodule

// File: rtl/greedy_aligned_pack_planner_unit.sv
// Greedy aligned pack planner, top level: front end, plan queue, back end.
// Depends on gapp_pkg, gapp_front, gapp_queue, gapp_back.
//
//  channel  | handshake                      | word
//  ---------+--------------------------------+-------------------------------------
//  config   | i_cfg_we                       | i_cfg_idx, i_cfg_data
//  tile     | i_tile_valid / o_tile_ready    | key, face, level, payload, final
//  range    | o_range_valid / i_range_ready  | start, count, status, last result
//
// One tile per cycle; a tile that closes a range and ends the list yields two
// consecutive range words. Each plan word is registered in the plan queue, then
// in the back end. Reset is synchronous and needs no clearing pass.
// Output stalls fill the plan queue (QUEUE_DEPTH words), then drop o_tile_ready.
module greedy_aligned_pack_planner_unit #(
    parameter int QUEUE_DEPTH = gapp_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gapp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gapp_pkg::TARGET_W-1:0]   i_cfg_data,
    input  logic                            i_tile_valid,
    output logic                            o_tile_ready,
    input  logic [gapp_pkg::KEY_W-1:0]      i_tile_key,
    input  logic [gapp_pkg::FACE_W-1:0]     i_tile_face,
    input  logic [gapp_pkg::LEVEL_W-1:0]    i_tile_level,
    input  logic [gapp_pkg::PAYLOAD_W-1:0]  i_payload_size,
    input  logic                            i_final_tile,
    output logic                            o_range_valid,
    input  logic                            i_range_ready,
    output logic [gapp_pkg::START_W-1:0]    o_range_start,
    output logic [gapp_pkg::COUNT_W-1:0]    o_range_count,
    output logic [gapp_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_last_result
);
    import gapp_pkg::*;

    logic  w_push, w_pop, w_empty, w_full;
    t_plan w_plan, w_head;

    gapp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_tile_valid   (i_tile_valid),
        .o_tile_ready   (o_tile_ready),
        .i_tile_key     (i_tile_key),
        .i_tile_face    (i_tile_face),
        .i_tile_level   (i_tile_level),
        .i_payload_size (i_payload_size),
        .i_final_tile   (i_final_tile),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_plan         (w_plan)
    );

    gapp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_plan  (w_plan),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    gapp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_range_valid (o_range_valid),
        .i_range_ready (i_range_ready),
        .o_range_start (o_range_start),
        .o_range_count (o_range_count),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

endmodule

// File: verif/pack_range_checker.sv
`timescale 1ns / 100ps
// Range checker for the pack planner bench: follows register writes and accepted
// tiles, plans the pack ranges they close and compares every range word taken.
// Depends on gapp_pkg.
module pack_range_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gapp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gapp_pkg::TARGET_W-1:0]  i_cfg_data,
    input  logic                           i_tile_valid,
    input  logic                           i_tile_ready,
    input  logic [gapp_pkg::KEY_W-1:0]     i_tile_key,
    input  logic [gapp_pkg::FACE_W-1:0]    i_tile_face,
    input  logic [gapp_pkg::LEVEL_W-1:0]   i_tile_level,
    input  logic [gapp_pkg::PAYLOAD_W-1:0] i_payload_size,
    input  logic                           i_final_tile,
    input  logic                           i_range_valid,
    input  logic                           i_range_ready,
    input  logic [gapp_pkg::START_W-1:0]   i_range_start,
    input  logic [gapp_pkg::COUNT_W-1:0]   i_range_count,
    input  logic [gapp_pkg::STATUS_W-1:0]  i_status,
    input  logic                           i_last_result,
    output int                             o_fail_count,
    output int                             o_ranges_due
);
    import gapp_pkg::*;

    logic [TARGET_W-1:0] target_size;
    logic [HEADER_W-1:0] header_size;
    logic [COUNT_W-1:0]  tile_idx;
    logic [START_W-1:0]  range_first;
    logic [63:0]         range_bytes;
    logic [FACE_W-1:0]   range_face;
    logic [LEVEL_W-1:0]  range_level;
    logic [KEY_W-1:0]    last_key;
    logic                range_open;
    logic                error_seen;
    t_result             due_ranges[$];
    int                  mismatches = 0;

    task automatic push_range(input logic [START_W-1:0] first, input logic [COUNT_W-1:0] cnt,
                              input logic [STATUS_W-1:0] st, input logic fin);
        t_result r;
        r.start  = first;
        r.count  = cnt;
        r.status = st;
        r.last   = fin;
        due_ranges = {due_ranges, r};
    endtask

    task automatic close_list();
        tile_idx    = '0;
        last_key    = '0;
        range_open  = 1'b0;
        range_first = '0;
        range_bytes = '0;
    endtask

    task automatic plan_tile(input logic [KEY_W-1:0] key, input logic [FACE_W-1:0] face,
                             input logic [LEVEL_W-1:0] level,
                             input logic [PAYLOAD_W-1:0] payload, input logic fin);
        logic [63:0] fill;
        logic        fresh;
        if (error_seen) return;
        // list overrun: tiles ignored, final one still closes the list
        if (tile_idx >= MAX_TILES) begin
            if (fin) begin
                if (range_open)
                    push_range(range_first, tile_idx - range_first, ST_OK, 1'b1);
                else
                    push_range('0, '0, ST_OK, 1'b1);
                close_list();
            end
            return;
        end
        if (payload[PAYLOAD_W-1]) begin
            error_seen = 1'b1;
            push_range('0, '0, ST_PAYLOAD, 1'b1);
            return;
        end
        if (tile_idx != 0 && key <= last_key) begin
            error_seen = 1'b1;
            push_range('0, '0, ST_KEY_ORDER, 1'b1);
            return;
        end
        fresh = 1'b1;
        if (range_open) begin
            if (face == range_face && level == range_level) begin
                fill = ((range_bytes + 64'd7) & ~64'd7) + 64'(payload);
                if (fill <= 64'(target_size)) begin
                    range_bytes = fill;
                    fresh = 1'b0;
                end
            end
            if (fresh)
                push_range(range_first, tile_idx - range_first, ST_OK, 1'b0);
        end
        if (fresh) begin
            range_open  = 1'b1;
            range_first = tile_idx[START_W-1:0];
            range_bytes = ((64'(header_size) + 64'd7) & ~64'd7) + 64'(payload);
            range_face  = face;
            range_level = level;
        end
        tile_idx = tile_idx + 1'b1;
        last_key = key;
        if (fin) begin
            push_range(range_first, tile_idx - range_first, ST_OK, 1'b1);
            close_list();
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            target_size = TARGET_RESET;
            header_size = HEADER_RESET;
            range_face  = '0;
            range_level = '0;
            error_seen  = 1'b0;
            close_list();
            due_ranges.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET: target_size = i_cfg_data;
                    CFG_HEADER: header_size = i_cfg_data[HEADER_W-1:0];
                    default: ;
                endcase
            end
            if (i_range_valid && i_range_ready) begin
                if (due_ranges.size() == 0) begin
                    $error("range word with nothing due: start %0d count %0d status %0d",
                           i_range_start, i_range_count, i_status);
                    mismatches++;
                end else begin
                    want = due_ranges.pop_front();
                    compare_field("range_start", 32'(want.start), 32'(i_range_start));
                    compare_field("range_count", 32'(want.count), 32'(i_range_count));
                    compare_field("status", 32'(want.status), 32'(i_status));
                    compare_field("last_result", 32'(want.last), 32'(i_last_result));
                end
            end
            if (i_tile_valid && i_tile_ready)
                plan_tile(i_tile_key, i_tile_face, i_tile_level, i_payload_size, i_final_tile);
        end
        o_ranges_due <= due_ranges.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: verif/greedy_aligned_pack_planner_unit_tb.sv
`timescale 1ns / 100ps
// Bench top for the pack planner: clock, reset, tile and register stimulus,
// random output stalls and the verdict. Depends on gapp_pkg, pack_range_checker
// and the planner RTL.
module greedy_aligned_pack_planner_unit_tb;
    import gapp_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TARGET_W-1:0]  i_cfg_data;
    logic                 i_tile_valid;
    logic                 o_tile_ready;
    logic [KEY_W-1:0]     i_tile_key;
    logic [FACE_W-1:0]    i_tile_face;
    logic [LEVEL_W-1:0]   i_tile_level;
    logic [PAYLOAD_W-1:0] i_payload_size;
    logic                 i_final_tile;
    logic                 o_range_valid;
    logic                 i_range_ready = 1'b0;
    logic [START_W-1:0]   o_range_start;
    logic [COUNT_W-1:0]   o_range_count;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last_result;

    int                   fail_count;
    int                   ranges_due;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   tiles_sent     = 0;
    logic [TARGET_W-1:0]  cur_target     = TARGET_RESET;

    greedy_aligned_pack_planner_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_tile_valid   (i_tile_valid),
        .o_tile_ready   (o_tile_ready),
        .i_tile_key     (i_tile_key),
        .i_tile_face    (i_tile_face),
        .i_tile_level   (i_tile_level),
        .i_payload_size (i_payload_size),
        .i_final_tile   (i_final_tile),
        .o_range_valid  (o_range_valid),
        .i_range_ready  (i_range_ready),
        .o_range_start  (o_range_start),
        .o_range_count  (o_range_count),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

    pack_range_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_tile_valid   (i_tile_valid),
        .i_tile_ready   (o_tile_ready),
        .i_tile_key     (i_tile_key),
        .i_tile_face    (i_tile_face),
        .i_tile_level   (i_tile_level),
        .i_payload_size (i_payload_size),
        .i_final_tile   (i_final_tile),
        .i_range_valid  (o_range_valid),
        .i_range_ready  (i_range_ready),
        .i_range_start  (o_range_start),
        .i_range_count  (o_range_count),
        .i_status       (o_status),
        .i_last_result  (o_last_result),
        .o_fail_count   (fail_count),
        .o_ranges_due   (ranges_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_range_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_tile(input logic [KEY_W-1:0] key, input logic [FACE_W-1:0] face,
                             input logic [LEVEL_W-1:0] level,
                             input logic [PAYLOAD_W-1:0] payload, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_tile_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_tile_valid   <= 1'b1;
        i_tile_key     <= key;
        i_tile_face    <= face;
        i_tile_level   <= level;
        i_payload_size <= payload;
        i_final_tile   <= fin;
        @(posedge i_clk);
        while (!o_tile_ready) @(posedge i_clk);
        tiles_sent++;
    endtask

    // hold off until every range word due has been taken, then let the pipe empty
    task automatic settle();
        i_tile_valid <= 1'b0;
        @(posedge i_clk);
        while (ranges_due != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        logic [TARGET_W-1:0] part;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PAYLOAD_W'($urandom_range(0, 16));
            2, 3: return PAYLOAD_W'($urandom_range(0, 600));
            4: return {1'b0, $urandom};
            5: return {1'b0, 32'hFFFF_FFFF};
            default: begin
                part = cur_target / TARGET_W'($urandom_range(2, 8));
                if (part > TARGET_W'(32'hFFFF_FFFF))
                    return {1'b0, $urandom};
                return PAYLOAD_W'(part);
            end
        endcase
    endfunction

    task automatic send_list(input int len, input bit pause_mid);
        logic [KEY_W-1:0]   key;
        logic [FACE_W-1:0]  face;
        logic [LEVEL_W-1:0] level;
        key = {$urandom, $urandom};
        if (&key[63:32])
            key[63] = 1'b0;
        face  = FACE_W'($urandom);
        level = LEVEL_W'($urandom);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 1))
                    face = FACE_W'($urandom);
                else
                    level = LEVEL_W'($urandom);
            end
            send_tile(key, face, level, random_payload(), n == len - 1);
            if (pause_mid && n == len / 2)
                settle();
            key = key + 64'd1 + 64'($urandom_range(0, 1 << $urandom_range(0, 20)));
        end
    endtask

    task automatic write_regs(input logic [TARGET_W-1:0] target, input logic [HEADER_W-1:0] hdr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TARGET;
        i_cfg_data <= target;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEADER;
        i_cfg_data <= TARGET_W'(hdr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_target = target;
    endtask

    task automatic run_phase(input logic [TARGET_W-1:0] target, input logic [HEADER_W-1:0] hdr,
                             input int idle, input int stall, input int words,
                             input bit pause);
        int goal;
        settle();
        write_regs(target, hdr);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        goal = tiles_sent + words;
        while (tiles_sent < goal) begin
            if ($urandom_range(0, 9) == 0)
                send_list($urandom_range(30, 64), pause);
            else
                send_list($urandom_range(1, 16), pause);
            pause = 1'b0;
        end
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0]   key;
        logic [FACE_W-1:0]  face;
        logic [LEVEL_W-1:0] level;
        int                 kind;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_TARGET;
        i_cfg_data     <= '0;
        i_tile_valid   <= 1'b0;
        i_tile_key     <= '0;
        i_tile_face    <= '0;
        i_tile_level   <= '0;
        i_payload_size <= '0;
        i_final_tile   <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: exact fill to the target, alignment, face and level changes
        send_tile(64'd0, 8'd0, 8'd0, 33'd0, 1'b0);
        send_tile(64'd1, 8'd0, 8'd0, 33'd16777152, 1'b0);
        send_tile(64'd2, 8'd0, 8'd0, 33'd0, 1'b0);
        send_tile(64'd3, 8'd0, 8'd0, 33'd1, 1'b0);
        send_tile(64'd4, 8'd0, 8'd0, 33'd0, 1'b0);
        send_tile(64'd5, 8'hFF, 8'd0, 33'd7, 1'b0);
        send_tile(64'd6, 8'hFF, 8'hFF, 33'd8, 1'b0);
        send_tile(64'd7, 8'hFF, 8'hFF, 33'h0_FFFF_FFFF, 1'b0);
        send_tile(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 33'd0, 1'b1);
        // new list: first key is not checked against the old one
        send_tile(64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 8'hA5, 33'd5, 1'b1);
        send_tile(64'd10, 8'hA5, 8'h5A, 33'd3, 1'b0);
        send_tile(64'd11, 8'hA5, 8'h5A, 33'd4, 1'b1);

        run_phase('0, '0, 0, 0, 105, 1'b0);
        run_phase(TARGET_W'(1), 13'd4096, 77, 0, 105, 1'b0);
        run_phase(41'h100_0000_0000, 13'h1FFF, 0, 77, 105, 1'b0);
        run_phase(TARGET_W'($urandom_range(64, 4096)), HEADER_W'($urandom_range(0, 4096)),
                  20, 20, 105, 1'b0);
        run_phase(TARGET_W'($urandom), HEADER_W'($urandom_range(0, 4096)), 0, 0, 105, 1'b1);
        run_phase({9'($urandom_range(0, 511)), $urandom}, HEADER_W'($urandom_range(0, 4096)),
                  20, 20, 105, 1'b0);

        // error goes last: it latches the block until reset
        settle();
        kind  = $urandom_range(0, 2);
        key   = 64'($urandom) + 64'd100;
        face  = FACE_W'($urandom);
        level = LEVEL_W'($urandom);
        for (int n = 0; n < 3; n++)
            send_tile(key + 64'(n), face, level, random_payload(), 1'b0);
        case (kind)
            0: send_tile(key + 64'd3, face, level, {1'b1, $urandom}, 1'b0);
            1: send_tile(key + 64'd2 - 64'($urandom_range(0, 1)), face, level,
                         random_payload(), 1'b0);
            default: send_tile(key + 64'd1, face, level, {1'b1, $urandom}, 1'b0);
        endcase
        for (int n = 0; n < 4; n++)
            send_tile({$urandom, $urandom}, FACE_W'($urandom), LEVEL_W'($urandom),
                      {1'($urandom_range(0, 1)), $urandom}, 1'($urandom_range(0, 1)));

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && ranges_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
